FILE: rtl/krl_pkg.sv
// Package for the keyed record list: field widths, command codes, and the
// control/status structs between the controller and the datapath. No dependencies.
package krl_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned PayW     = 64;
  localparam int unsigned PosW     = 7;
  localparam int unsigned CntOutW  = 7;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_FRONT     = 3'd1,
    CMD_SORTED    = 3'd2,
    CMD_REM_LAST  = 3'd3,
    CMD_REM_FIRST = 3'd4,
    CMD_REM_KEY   = 3'd5,
    CMD_READ_POS  = 3'd6,
    CMD_FIND      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_IDX_M1 = 2'd1,
    RD_IDX_P1 = 2'd2,
    RD_POS    = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_INC  = 2'd1,
    IDX_DEC  = 2'd2,
    IDX_CNT  = 2'd3
  } idx_op_e;

  typedef enum logic [1:0] {
    AT_HOLD = 2'd0,
    AT_IDX  = 2'd1,
    AT_CNT  = 2'd2,
    AT_ZERO = 2'd3
  } at_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef struct packed {
    logic    load;
    logic    rd;
    rd_sel_e rd_sel;
    logic    wr;
    logic    wr_new;
    idx_op_e idx_op;
    at_sel_e at_sel;
    cnt_op_e cnt_op;
    logic    pub;
    logic    pub_ok;
    logic    pub_found;
  } krl_ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic idx_lt_cnt;
    logic idx_gt_at;
    logic idxp1_lt_cnt;
    logic key_eq;
    logic key_lt;
    logic pos_ok;
    logic out_busy;
  } krl_stat_t;

endpackage

FILE: rtl/krl_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on krl_pkg for field widths.
interface krl_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          command;
  logic signed [krl_pkg::KeyW-1:0]     record_key;
  logic [krl_pkg::PayW-1:0]            record_payload;
  logic [krl_pkg::PosW-1:0]            position;

  modport source (output valid, command, record_key, record_payload, position, input ready);
  modport sink (input valid, command, record_key, record_payload, position, output ready);
endinterface

interface krl_out_if;
  logic                                valid;
  logic                                ready;
  logic                                success;
  logic signed [krl_pkg::KeyW-1:0]     found_key;
  logic [krl_pkg::PayW-1:0]            found_payload;
  logic [krl_pkg::CntOutW-1:0]         entry_count;
  logic                                is_full;
  logic                                is_empty;

  modport source (output valid, success, found_key, found_payload, entry_count, is_full,
                  is_empty, input ready);
  modport sink (input valid, success, found_key, found_payload, entry_count, is_full,
                is_empty, output ready);
endinterface

FILE: rtl/krl_datapath.sv
// Datapath: record memories, position/count registers, compare logic and
// result register. Depends on krl_pkg.
module krl_datapath #(
  parameter int unsigned CAPACITY = krl_pkg::Capacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [2:0]                       cmd_i,
  input  logic signed [krl_pkg::KeyW-1:0]  key_i,
  input  logic [krl_pkg::PayW-1:0]         payload_i,
  input  logic [krl_pkg::PosW-1:0]         pos_i,
  input  krl_pkg::krl_ctrl_t               ctrl_i,
  output krl_pkg::krl_stat_t               stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             success_o,
  output logic signed [krl_pkg::KeyW-1:0]  found_key_o,
  output logic [krl_pkg::PayW-1:0]         found_payload_o,
  output logic [krl_pkg::CntOutW-1:0]      entry_count_o,
  output logic                             is_full_o,
  output logic                             is_empty_o
);
  import krl_pkg::*;

  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW   = $clog2(CAPACITY);
  localparam int unsigned PosExtW = (CntW > PosW) ? CntW : PosW;

  logic [KeyW-1:0] mem_key [CAPACITY];
  logic [PayW-1:0] mem_pay [CAPACITY];

  cmd_e            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [PayW-1:0] pay_q;
  logic [PosW-1:0] pos_q;
  logic [KeyW-1:0] rdk_q;
  logic [PayW-1:0] rdp_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] at_q, at_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic                out_valid_q;
  logic                ok_q;
  logic [KeyW-1:0]     fk_q;
  logic [PayW-1:0]     fp_q;
  logic [CntOutW-1:0]  oc_q;
  logic                of_q;
  logic                oe_q;

  logic [CntW-1:0]    idx_m1, idx_p1;
  logic [CntW:0]      idx_p1_ext;
  logic [PosExtW-1:0] pos_ext, pos_m1, cnt_ext;
  logic [AddrW-1:0]   rd_addr;
  logic               full, empty;

  assign idx_m1     = idx_q - CntW'(1);
  assign idx_p1     = idx_q + CntW'(1);
  assign idx_p1_ext = {1'b0, idx_q} + (CntW + 1)'(1);
  assign pos_ext    = PosExtW'(pos_q);
  assign pos_m1     = pos_ext - PosExtW'(1);
  assign cnt_ext    = PosExtW'(cnt_q);
  assign full       = (cnt_q == CntW'(CAPACITY));
  assign empty      = (cnt_q == '0);

  always_comb begin
    case (ctrl_i.rd_sel)
      RD_IDX:    rd_addr = idx_q[AddrW-1:0];
      RD_IDX_M1: rd_addr = idx_m1[AddrW-1:0];
      RD_IDX_P1: rd_addr = idx_p1[AddrW-1:0];
      RD_POS:    rd_addr = pos_m1[AddrW-1:0];
      default:   rd_addr = idx_q[AddrW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_key[idx_q[AddrW-1:0]] <= ctrl_i.wr_new ? key_q : rdk_q;
      mem_pay[idx_q[AddrW-1:0]] <= ctrl_i.wr_new ? pay_q : rdp_q;
    end
    if (ctrl_i.rd) begin
      rdk_q <= mem_key[rd_addr];
      rdp_q <= mem_pay[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i;
      pay_q <= payload_i;
      pos_q <= pos_i;
    end
  end

  always_comb begin
    case (ctrl_i.idx_op)
      IDX_HOLD: idx_d = idx_q;
      IDX_INC:  idx_d = idx_p1;
      IDX_DEC:  idx_d = idx_m1;
      IDX_CNT:  idx_d = cnt_q;
      default:  idx_d = idx_q;
    endcase
    if (ctrl_i.load) begin
      idx_d = '0;
    end
    case (ctrl_i.at_sel)
      AT_HOLD: at_d = at_q;
      AT_IDX:  at_d = idx_q;
      AT_CNT:  at_d = cnt_q;
      AT_ZERO: at_d = '0;
      default: at_d = at_q;
    endcase
    case (ctrl_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CntW'(1);
      CNT_DEC: cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      at_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      at_q  <= at_d;
      cnt_q <= cnt_d;
      if (ctrl_i.pub) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pub) begin
      ok_q <= ctrl_i.pub_ok;
      fk_q <= ctrl_i.pub_found ? rdk_q : '0;
      fp_q <= ctrl_i.pub_found ? rdp_q : '0;
      oc_q <= cnt_ext[CntOutW-1:0];
      of_q <= full;
      oe_q <= empty;
    end
  end

  assign stat_o.cmd          = cmd_q;
  assign stat_o.full         = full;
  assign stat_o.empty        = empty;
  assign stat_o.idx_lt_cnt   = (idx_q < cnt_q);
  assign stat_o.idx_gt_at    = (idx_q > at_q);
  assign stat_o.idxp1_lt_cnt = (idx_p1_ext < {1'b0, cnt_q});
  assign stat_o.key_eq       = (rdk_q == key_q);
  assign stat_o.key_lt       = ($signed(rdk_q) < $signed(key_q));
  assign stat_o.pos_ok       = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign stat_o.out_busy     = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign success_o       = ok_q;
  assign found_key_o     = fk_q;
  assign found_payload_o = fp_q;
  assign entry_count_o   = oc_q;
  assign is_full_o       = of_q;
  assign is_empty_o      = oe_q;

endmodule

FILE: rtl/krl_ctrl.sv
// Controller state machine: sequences scans, entry shifts, reads and result
// publication for each command. Depends on krl_pkg.
module krl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  krl_pkg::krl_stat_t stat_i,
  output krl_pkg::krl_ctrl_t ctrl_o
);
  import krl_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_CK = 4'd3;
  localparam logic [3:0] S_UP_CHK  = 4'd4;
  localparam logic [3:0] S_UP_WR   = 4'd5;
  localparam logic [3:0] S_DN_CHK  = 4'd6;
  localparam logic [3:0] S_DN_WR   = 4'd7;
  localparam logic [3:0] S_PUT     = 4'd8;
  localparam logic [3:0] S_RD_WAIT = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_q, state_d;
  logic       ok_q, ok_d;
  logic       found_q, found_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.rd_sel  = RD_IDX;
    ctrl_o.idx_op  = IDX_HOLD;
    ctrl_o.at_sel  = AT_HOLD;
    ctrl_o.cnt_op  = CNT_HOLD;
    state_d        = state_q;
    ok_d           = ok_q;
    found_d        = found_q;

    case (state_q)
      S_IDLE: begin
        ok_d    = 1'b0;
        found_d = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.cmd)
          CMD_APPEND, CMD_FRONT: begin
            if (stat_i.full) begin
              state_d = S_FIN;
            end else begin
              ctrl_o.at_sel = (stat_i.cmd == CMD_APPEND) ? AT_CNT : AT_ZERO;
              ctrl_o.idx_op = IDX_CNT;
              state_d       = S_UP_CHK;
            end
          end
          CMD_SORTED: begin
            state_d = stat_i.full ? S_FIN : S_SCAN_RD;
          end
          CMD_REM_LAST: begin
            if (!stat_i.empty) begin
              ctrl_o.cnt_op = CNT_DEC;
              ok_d          = 1'b1;
            end
            state_d = S_FIN;
          end
          CMD_REM_FIRST: begin
            state_d = stat_i.empty ? S_FIN : S_DN_CHK;
          end
          CMD_READ_POS: begin
            if (stat_i.pos_ok) begin
              ctrl_o.rd     = 1'b1;
              ctrl_o.rd_sel = RD_POS;
              state_d       = S_RD_WAIT;
            end else begin
              state_d = S_FIN;
            end
          end
          default: begin
            state_d = S_SCAN_RD;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (stat_i.idx_lt_cnt) begin
          ctrl_o.rd = 1'b1;
          state_d   = S_SCAN_CK;
        end else if (stat_i.cmd == CMD_SORTED) begin
          ctrl_o.at_sel = AT_IDX;
          ctrl_o.idx_op = IDX_CNT;
          state_d       = S_UP_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN_CK: begin
        if (stat_i.cmd == CMD_SORTED) begin
          if (stat_i.key_lt) begin
            ctrl_o.idx_op = IDX_INC;
            state_d       = S_SCAN_RD;
          end else begin
            ctrl_o.at_sel = AT_IDX;
            ctrl_o.idx_op = IDX_CNT;
            state_d       = S_UP_CHK;
          end
        end else if (stat_i.key_eq) begin
          if (stat_i.cmd == CMD_FIND) begin
            ok_d    = 1'b1;
            found_d = 1'b1;
            state_d = S_FIN;
          end else begin
            state_d = S_DN_CHK;
          end
        end else begin
          ctrl_o.idx_op = IDX_INC;
          state_d       = S_SCAN_RD;
        end
      end
      S_UP_CHK: begin
        if (stat_i.idx_gt_at) begin
          ctrl_o.rd     = 1'b1;
          ctrl_o.rd_sel = RD_IDX_M1;
          state_d       = S_UP_WR;
        end else begin
          state_d = S_PUT;
        end
      end
      S_UP_WR: begin
        ctrl_o.wr     = 1'b1;
        ctrl_o.idx_op = IDX_DEC;
        state_d       = S_UP_CHK;
      end
      S_PUT: begin
        ctrl_o.wr     = 1'b1;
        ctrl_o.wr_new = 1'b1;
        ctrl_o.cnt_op = CNT_INC;
        ok_d          = 1'b1;
        state_d       = S_FIN;
      end
      S_DN_CHK: begin
        if (stat_i.idxp1_lt_cnt) begin
          ctrl_o.rd     = 1'b1;
          ctrl_o.rd_sel = RD_IDX_P1;
          state_d       = S_DN_WR;
        end else begin
          ctrl_o.cnt_op = CNT_DEC;
          ok_d          = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_DN_WR: begin
        ctrl_o.wr     = 1'b1;
        ctrl_o.idx_op = IDX_INC;
        state_d       = S_DN_CHK;
      end
      S_RD_WAIT: begin
        ok_d    = 1'b1;
        found_d = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          ctrl_o.pub       = 1'b1;
          ctrl_o.pub_ok    = ok_q;
          ctrl_o.pub_found = found_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ok_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
      found_q <= found_d;
    end
  end

endmodule

FILE: rtl/keyed_record_list_unit.sv
// Keyed record list, top level: joins the controller and the datapath to the
// command and result channels. Depends on krl_pkg, krl_if, krl_ctrl, krl_datapath.
//
// Holds up to CAPACITY records (signed 32-bit key, 64-bit payload) in two
// single-port-write, registered-read memories walked one entry at a time.
// One command is in flight at a time. Remove last, and any insert when full
// or any remove-first or read when it fails at once, go straight to the
// result; read position reads its one entry; append writes at the end;
// insert front shifts every entry up; remove first shifts the entries after
// the first down; find scans until a match or the end; remove key scans the
// same way and on a match shifts the later entries down; insert sorted scans
// to the first entry not below the key, then shifts the rest up. Each entry
// moved or compared takes one access of the memory read port.
// A finished result sits in an output register, so the next command is taken
// the cycle after the result is published and runs while it waits; that
// command stalls before publishing until the waiting result is transferred.
module keyed_record_list_unit #(
  parameter int unsigned CAPACITY = krl_pkg::Capacity
) (
  input logic    clk_i,
  input logic    rst_ni,
  krl_in_if.sink   req_i,
  krl_out_if.source rsp_o
);
  import krl_pkg::*;

  krl_ctrl_t ctrl;
  krl_stat_t stat;

  krl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  krl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (req_i.command),
    .key_i           (req_i.record_key),
    .payload_i       (req_i.record_payload),
    .pos_i           (req_i.position),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .success_o       (rsp_o.success),
    .found_key_o     (rsp_o.found_key),
    .found_payload_o (rsp_o.found_payload),
    .entry_count_o   (rsp_o.entry_count),
    .is_full_o       (rsp_o.is_full),
    .is_empty_o      (rsp_o.is_empty)
  );

endmodule

FILE: rtl/krl_checker.sv
// Port-level checks on the keyed record list results, bound to the top level.
// Depends on krl_pkg and keyed_record_list_unit.
module krl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             success_i,
  input logic [krl_pkg::KeyW-1:0]         found_key_i,
  input logic [krl_pkg::PayW-1:0]         found_payload_i,
  input logic [krl_pkg::CntOutW-1:0]      entry_count_i,
  input logic                             is_full_i,
  input logic                             is_empty_i
);
  import krl_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(entry_count_i) && $stable(success_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(is_full_i && is_empty_i))
    else $error("list reported both full and empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_empty_i == (entry_count_i == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !success_i |-> (found_key_i == '0) && (found_payload_i == '0))
    else $error("failed command returned an entry");

endmodule

bind keyed_record_list_unit krl_checker u_krl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .success_i       (rsp_o.success),
  .found_key_i     (rsp_o.found_key),
  .found_payload_i (rsp_o.found_payload),
  .entry_count_i   (rsp_o.entry_count),
  .is_full_i       (rsp_o.is_full),
  .is_empty_i      (rsp_o.is_empty)
);

FILE: test/krl_check.sv
// Checker for the keyed record list: watches the command and result channels,
// keeps its own copy of the list, and compares every result. Depends on krl_pkg, krl_if.
module krl_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  krl_in_if.sink      cmd_mon,
  krl_out_if.sink     rsp_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import krl_pkg::*;

  typedef struct packed {
    logic                   success;
    logic signed [KeyW-1:0] found_key;
    logic [PayW-1:0]        found_payload;
    logic [CntOutW-1:0]     entry_count;
    logic                   is_full;
    logic                   is_empty;
  } list_result_t;

  logic signed [KeyW-1:0] list_keys[$];
  logic [PayW-1:0]        list_pays[$];
  list_result_t           expected_results[$];

  function automatic list_result_t apply_command(cmd_e cmd, logic signed [KeyW-1:0] k,
                                                 logic [PayW-1:0] p, logic [PosW-1:0] pos);
    list_result_t r;
    int i;
    r = '0;
    i = 0;
    case (cmd)
      CMD_APPEND: if (list_keys.size() < Capacity) begin
        list_keys.push_back(k); list_pays.push_back(p); r.success = 1'b1;
      end
      CMD_FRONT: if (list_keys.size() < Capacity) begin
        list_keys.push_front(k); list_pays.push_front(p); r.success = 1'b1;
      end
      CMD_SORTED: if (list_keys.size() < Capacity) begin
        while (i < list_keys.size() && list_keys[i] < k) i++;
        list_keys.insert(i, k); list_pays.insert(i, p); r.success = 1'b1;
      end
      CMD_REM_LAST: if (list_keys.size() > 0) begin
        void'(list_keys.pop_back()); void'(list_pays.pop_back()); r.success = 1'b1;
      end
      CMD_REM_FIRST: if (list_keys.size() > 0) begin
        void'(list_keys.pop_front()); void'(list_pays.pop_front()); r.success = 1'b1;
      end
      CMD_REM_KEY: begin
        while (i < list_keys.size() && list_keys[i] != k) i++;
        if (i < list_keys.size()) begin
          list_keys.delete(i); list_pays.delete(i); r.success = 1'b1;
        end
      end
      CMD_READ_POS: if (pos >= 1 && pos <= list_keys.size()) begin
        r.found_key = list_keys[pos-1]; r.found_payload = list_pays[pos-1]; r.success = 1'b1;
      end
      default: begin
        while (i < list_keys.size() && list_keys[i] != k) i++;
        if (i < list_keys.size()) begin
          r.found_key = list_keys[i]; r.found_payload = list_pays[i]; r.success = 1'b1;
        end
      end
    endcase
    r.entry_count = CntOutW'(list_keys.size());
    r.is_full = (list_keys.size() == Capacity);
    r.is_empty = (list_keys.size() == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got, want;
    if (!rst_ni) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        expected_results.push_back(apply_command(cmd_e'(cmd_mon.command), cmd_mon.record_key,
                                                 cmd_mon.record_payload, cmd_mon.position));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.success, rsp_mon.found_key, rsp_mon.found_payload,
                rsp_mon.entry_count, rsp_mon.is_full, rsp_mon.is_empty};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("result differs: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end
endmodule

FILE: test/tb.sv
// Testbench top for keyed_record_list_unit: drives directed and random command
// transfers with random stalls on both sides. Depends on krl_pkg, krl_if, krl_check.
module tb;
  import krl_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  int unsigned fail_count, pending, idle_cycles;
  bit          src_steady, snk_steady, hold_off;

  krl_in_if  cmd_ch ();
  krl_out_if rsp_ch ();

  keyed_record_list_unit DUT (.clk_i, .rst_ni, .req_i(cmd_ch), .rsp_o(rsp_ch));
  krl_check chk (.clk_i, .rst_ni, .cmd_mon(cmd_ch), .rsp_mon(rsp_ch), .fail_count, .pending);

  always #5 clk_i = ~clk_i;

  initial begin
    cmd_ch.valid = 0; cmd_ch.command = '0; cmd_ch.record_key = '0;
    cmd_ch.record_payload = '0; cmd_ch.position = '0;
    rsp_ch.ready = 0;
  end

  task automatic send_command(cmd_e cmd, logic signed [KeyW-1:0] k, logic [PayW-1:0] p,
                              logic [PosW-1:0] pos);
    while (!src_steady && $urandom_range(99) < 22) begin
      cmd_ch.valid <= 0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1; cmd_ch.command <= cmd; cmd_ch.record_key <= k;
    cmd_ch.record_payload <= p; cmd_ch.position <= pos;
    do @(posedge clk_i); while (!cmd_ch.ready);
    @(negedge clk_i);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(3))
      0: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom_range(7))};
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed(32'($urandom_range(15))) - 8;
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (hold_off) rsp_ch.ready <= 0;
    else rsp_ch.ready <= snk_steady || $urandom_range(99) >= 22;
  end

  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("keyed_record_list_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [PayW-1:0] pay;
    int n;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    pay = {$urandom, $urandom};
    send_command(CMD_REM_LAST, 0, 0, 0);
    send_command(CMD_REM_FIRST, 0, 0, 0);
    send_command(CMD_REM_KEY, 5, 0, 0);
    send_command(CMD_READ_POS, 0, 0, 1);
    send_command(CMD_FIND, 5, 0, 0);
    send_command(CMD_APPEND, 32'sh7fffffff, '1, 0);
    send_command(CMD_FRONT, 32'sh80000000, '0, 0);
    send_command(CMD_SORTED, 0, pay, 0);
    send_command(CMD_SORTED, 0, ~pay, 0);
    send_command(CMD_READ_POS, 0, 0, 0);
    send_command(CMD_READ_POS, 0, 0, 4);
    send_command(CMD_READ_POS, 0, 0, 5);
    send_command(CMD_READ_POS, 0, 0, 7'h7f);
    send_command(CMD_FIND, 0, 0, 0);
    send_command(CMD_REM_KEY, 0, 0, 0);
    send_command(CMD_REM_KEY, 32'sh80000000, 0, 0);
    send_command(CMD_REM_FIRST, 0, 0, 0);
    send_command(CMD_REM_LAST, 0, 0, 0);
    hold_off = 1;
    fork
      begin repeat (300) @(negedge clk_i); hold_off = 0; end
      repeat (8) send_command(CMD_APPEND, pick_key(), {$urandom, $urandom}, 0);
    join
    for (n = 0; n < 600; n++) begin
      src_steady = (n >= 200 && n < 260);
      snk_steady = src_steady;
      if (n >= 300 && n < 380)
        send_command(CMD_SORTED, pick_key(), {$urandom, $urandom}, 7'($urandom_range(127)));
      else if (n >= 380 && n < 420)
        send_command(cmd_e'($urandom_range(3, 5)), pick_key(), 0, 0);
      else
        send_command(cmd_e'($urandom_range(7)), pick_key(), {$urandom, $urandom},
                     $urandom_range(3) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(66)));
    end
    cmd_ch.valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("keyed_record_list_unit: match");
    else $display("keyed_record_list_unit: mismatch");
    $finish;
  end
endmodule
